// ----- rtl/ccmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ccmt_pkg
// shared types and constants of the character class transducer
// ----------------------------------------------------------------------------
package ccmt_pkg;

  localparam int MAX_STATES_DEF = 16;
  localparam int MAX_TRANS_DEF  = 8;
  localparam int MAX_OUT_DEF    = 16;

  localparam int CHUNKS    = 4;
  localparam int CHUNK_W   = 64;
  localparam int HDR_W     = 10;
  localparam int CODE_W    = 9;
  localparam int ST_W      = 4;
  localparam int LEN_W     = 5;

  // item opcodes
  localparam logic [2:0] OP_LOAD_CLASS = 3'd0;
  localparam logic [2:0] OP_LOAD_CODE  = 3'd1;
  localparam logic [2:0] OP_LOAD_HDR   = 3'd2;
  localparam logic [2:0] OP_PROCESS    = 3'd3;
  localparam logic [2:0] OP_RESTART    = 3'd4;

  localparam logic [CODE_W-1:0] CODE_ECHO = 9'd256;

  // register index of the config port
  localparam logic REG_START = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             fallback;
    logic [ST_W-1:0]  nxt;
  } hdr_t;

  typedef struct packed {
    logic hit;
    logic catch_hit;
  } eval_t;

endpackage

// ----- rtl/ccmt_ram.sv -----
// ----------------------------------------------------------------------------
// ccmt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ccmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ccmt_slot_eval.sv -----
// ----------------------------------------------------------------------------
// ccmt_slot_eval
// shared compare unit: tests one transition slot against the input byte
// ----------------------------------------------------------------------------
module ccmt_slot_eval (
  input  logic [ccmt_pkg::CHUNK_W-1:0] class_word,
  input  logic [5:0]                   bit_idx,
  input  logic                         slot_valid,
  input  ccmt_pkg::hdr_t               hdr,
  output ccmt_pkg::eval_t              result
);

  always_comb begin
    result.hit       = slot_valid && class_word[bit_idx];
    result.catch_hit = slot_valid && !class_word[bit_idx] && hdr.fallback;
  end

endmodule

// ----- rtl/char_class_mealy_transducer_unit.sv -----
// ----------------------------------------------------------------------------
// char_class_mealy_transducer_unit
// table driven mealy transducer over byte classes, one slot tested per step
// ----------------------------------------------------------------------------
// load and restart items: taken in the idle state, the input stays ready
// process item: a read and a check state per slot scanned (up to MAX_TRANS, one
//   shared slot compare fed by the class and header rams), a decide state, then
//   read and load per emitted byte (output ram read port); empty results use S_EMPTY
// reset: synchronous, clears valid marks, state and start register to 1;
//   the class, header and output rams hold no reset value and need no pass
module char_class_mealy_transducer_unit #(
  parameter int MAX_STATES = ccmt_pkg::MAX_STATES_DEF,
  parameter int MAX_TRANS  = ccmt_pkg::MAX_TRANS_DEF,
  parameter int MAX_OUT    = ccmt_pkg::MAX_OUT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata lsb up: state_sel[3:0] trans_sel[6:4] chunk_sel[8:7] class_bits[72:9]
  //   out_pos[76:73] out_code[85:77] next_state[89:86] out_len[94:90]
  //   is_fallback[95] char_in[103:96]
  input  logic [103:0] s_tdata,
  // tuser: opcode[2:0]
  input  logic [2:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: out_char[7:0]
  output logic [7:0]   m_tdata,
  // tlast: last_of_run
  output logic         m_tlast,
  // tuser lsb up: char_valid[0] machine_halted[1]
  output logic [1:0]   m_tuser,
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SLOTS   = MAX_STATES * MAX_TRANS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CA_W    = $clog2(SLOTS * ccmt_pkg::CHUNKS);
  localparam int OA_W    = $clog2(SLOTS * MAX_OUT);
  localparam int TC_W    = $clog2(MAX_TRANS + 1);
  localparam int LC_W    = $clog2(MAX_OUT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_OUT_RD, S_OUT_LD, S_EMPTY
  } state_t;

  // input fields
  logic [3:0]  state_sel;
  logic [2:0]  trans_sel;
  logic [1:0]  chunk_sel;
  logic [63:0] class_bits;
  logic [3:0]  out_pos;
  logic [8:0]  out_code;
  logic [3:0]  next_state;
  logic [4:0]  out_len;
  logic        is_fallback;
  logic [7:0]  char_in;
  logic [2:0]  opcode;

  assign state_sel    = s_tdata[3:0];
  assign trans_sel    = s_tdata[6:4];
  assign chunk_sel    = s_tdata[8:7];
  assign class_bits   = s_tdata[72:9];
  assign out_pos      = s_tdata[76:73];
  assign out_code     = s_tdata[85:77];
  assign next_state   = s_tdata[89:86];
  assign out_len      = s_tdata[94:90];
  assign is_fallback  = s_tdata[95];
  assign char_in      = s_tdata[103:96];
  assign opcode       = s_tuser;

  // sequencer registers
  state_t                  state;
  logic [ccmt_pkg::ST_W-1:0] cur_state;
  logic [ccmt_pkg::ST_W-1:0] start_state;
  logic [7:0]              char_reg;
  logic [TC_W-1:0]         tcnt;
  logic [LC_W-1:0]         ocnt;
  logic                    sel_ok;
  logic [SLOT_W-1:0]       sel_slot;
  ccmt_pkg::hdr_t          sel_hdr;
  logic [SLOTS-1:0]        valid_marks;

  logic in_xfer, out_free, cfg_wr;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ccmt_pkg::REG_START);
  assign prdata   = (paddr == ccmt_pkg::REG_START) ? {28'd0, start_state} : 32'd0;

  // a new result is loaded into the output register this cycle
  logic res_load;
  assign res_load = ((state == S_OUT_LD) || (state == S_EMPTY)) && out_free;

  // load slot address
  logic              load_in_range;
  logic [SLOT_W-1:0] load_slot;
  assign load_in_range = (int'(state_sel) < MAX_STATES) && (int'(trans_sel) < MAX_TRANS);
  assign load_slot     = SLOT_W'(int'(state_sel) * MAX_TRANS + int'(trans_sel));

  // slot under scan
  logic [SLOT_W-1:0] scan_slot;
  assign scan_slot = SLOT_W'(int'(cur_state) * MAX_TRANS + int'(tcnt));

  // class ram
  logic                         class_we;
  logic [CA_W-1:0]              class_waddr, class_raddr;
  logic [ccmt_pkg::CHUNK_W-1:0] class_rdata;
  assign class_we    = in_xfer && (opcode == ccmt_pkg::OP_LOAD_CLASS) && load_in_range;
  assign class_waddr = CA_W'(int'(load_slot) * ccmt_pkg::CHUNKS + int'(chunk_sel));
  assign class_raddr = CA_W'(int'(scan_slot) * ccmt_pkg::CHUNKS + int'(char_reg[7:6]));

  ccmt_ram #(.WIDTH(ccmt_pkg::CHUNK_W), .DEPTH(SLOTS * ccmt_pkg::CHUNKS)) u_class_ram (
    .clk   (clk),
    .we    (class_we),
    .waddr (class_waddr),
    .wdata (class_bits),
    .raddr (class_raddr),
    .rdata (class_rdata)
  );

  // header ram, length saturated on the way in
  logic                       hdr_we;
  ccmt_pkg::hdr_t             hdr_wdata, hdr_rdata;
  assign hdr_we = in_xfer && (opcode == ccmt_pkg::OP_LOAD_HDR) && load_in_range;
  always_comb begin
    hdr_wdata.nxt       = next_state;
    hdr_wdata.fallback  = is_fallback;
    hdr_wdata.len       = (int'(out_len) > MAX_OUT) ? ccmt_pkg::LEN_W'(MAX_OUT) : out_len;
  end

  ccmt_ram #(.WIDTH(ccmt_pkg::HDR_W), .DEPTH(SLOTS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (load_slot),
    .wdata (hdr_wdata),
    .raddr (scan_slot),
    .rdata (hdr_rdata)
  );

  // output code ram
  logic                        code_we;
  logic [OA_W-1:0]             code_waddr, code_raddr;
  logic [ccmt_pkg::CODE_W-1:0] code_rdata;
  assign code_we    = in_xfer && (opcode == ccmt_pkg::OP_LOAD_CODE) && load_in_range
                      && (int'(out_pos) < MAX_OUT);
  assign code_waddr = OA_W'(int'(load_slot) * MAX_OUT + int'(out_pos));
  assign code_raddr = OA_W'(int'(sel_slot) * MAX_OUT + int'(ocnt));

  ccmt_ram #(.WIDTH(ccmt_pkg::CODE_W), .DEPTH(SLOTS * MAX_OUT)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (code_waddr),
    .wdata (out_code),
    .raddr (code_raddr),
    .rdata (code_rdata)
  );

  // shared slot compare
  ccmt_pkg::eval_t ev;
  ccmt_slot_eval u_eval (
    .class_word (class_rdata),
    .bit_idx    (char_reg[5:0]),
    .slot_valid (valid_marks[scan_slot]),
    .hdr        (hdr_rdata),
    .result     (ev)
  );

  // next state after the chosen slot, out of range means end
  logic [ccmt_pkg::ST_W-1:0] dest_state, restart_state;
  assign dest_state    = (int'(sel_hdr.nxt) < MAX_STATES) ? sel_hdr.nxt : '0;
  assign restart_state = (int'(start_state) < MAX_STATES) ? start_state : '0;

  logic last_code;
  assign last_code = (int'(ocnt) + 1 == int'(sel_hdr.len));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_state   <= ccmt_pkg::ST_W'(1);
      start_state <= ccmt_pkg::ST_W'(1);
      valid_marks <= '0;
      m_tvalid    <= 1'b0;
      tcnt        <= '0;
      ocnt        <= '0;
      sel_ok      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_state <= pwdata[ccmt_pkg::ST_W-1:0];
      end
      // output register empties on a transfer unless refilled right away
      if (m_tvalid && m_tready && !res_load) begin
        m_tvalid <= 1'b0;
      end
      if (hdr_we) begin
        valid_marks[load_slot] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (opcode == ccmt_pkg::OP_RESTART) begin
              cur_state <= restart_state;
            end else if (opcode == ccmt_pkg::OP_PROCESS) begin
              char_reg <= char_in;
              tcnt     <= '0;
              sel_ok   <= 1'b0;
              // halted machine answers with an empty result
              state    <= (cur_state == '0) ? S_EMPTY : S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (ev.hit || ev.catch_hit) begin
            sel_ok   <= 1'b1;
            sel_slot <= scan_slot;
            sel_hdr  <= hdr_rdata;
          end
          // first match ends the scan, catch-all keeps the latest one
          if (ev.hit || (int'(tcnt) == MAX_TRANS - 1)) begin
            state <= S_DECIDE;
          end else begin
            tcnt  <= tcnt + TC_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_DECIDE: begin
          ocnt <= '0;
          if (sel_ok) begin
            cur_state <= dest_state;
            state     <= (sel_hdr.len == '0) ? S_EMPTY : S_OUT_RD;
          end else begin
            state <= S_EMPTY;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= (code_rdata >= ccmt_pkg::CODE_ECHO) ? char_reg : code_rdata[7:0];
            m_tuser    <= {(cur_state == '0), 1'b1};
            m_tlast    <= last_code;
            ocnt       <= ocnt + LC_W'(1);
            state      <= last_code ? S_IDLE : S_OUT_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 8'd0;
            m_tuser  <= {(cur_state == '0), 1'b0};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a process transfer always keeps the input side closed for the next cycle
  a_proc_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (opcode == ccmt_pkg::OP_PROCESS) |=> !s_tready)
    else $error("input ready right after a process transfer");

  // an empty result is always the last of its run and carries a zero byte
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'd0))
    else $error("empty result not final or not zero");

  // a halted machine only leaves end through restart
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (cur_state == '0) && !(in_xfer && (opcode == ccmt_pkg::OP_RESTART))
    |=> (cur_state == '0))
    else $error("left end state without restart");

  // a result is loaded only from an emission state
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT_LD) || ($past(state) == S_EMPTY))
    else $error("result appeared outside emission");

endmodule

// ----- tb/ccmt_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccmt_checker
// watches the item, result and register channels of the transducer, keeps
// its own copy of the slot tables and state, and compares every result
// transfer with the oldest predicted byte
// ----------------------------------------------------------------------------
module ccmt_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [7:0]   m_tdata,
  input  logic         m_tlast,
  input  logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           errors,
  output int           pending
);

  localparam int NST  = ccmt_pkg::MAX_STATES_DEF;
  localparam int NTR  = ccmt_pkg::MAX_TRANS_DEF;
  localparam int NOUT = ccmt_pkg::MAX_OUT_DEF;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_run;
    logic       halted;
  } emit_t;

  logic [ccmt_pkg::CHUNK_W-1:0] class_mem [NST*NTR*ccmt_pkg::CHUNKS];
  ccmt_pkg::hdr_t               hdr_mem   [NST*NTR];
  bit                           slot_on   [NST*NTR];
  logic [ccmt_pkg::CODE_W-1:0]  code_mem  [NST*NTR*NOUT];
  logic [ccmt_pkg::ST_W-1:0]    cur_st;
  logic [ccmt_pkg::ST_W-1:0]    start_st;
  emit_t                        emit_q [$];

  task automatic apply_item(input logic [2:0] op, input logic [103:0] d);
    logic [3:0] ss;
    logic [2:0] ts;
    logic [1:0] cs;
    logic [7:0] ch;
    logic [4:0] len;
    int         slot;
    int         base;
    int         chosen;
    int         fb;
    int         s;
    int         n;
    emit_t      run [NOUT];
    logic [ccmt_pkg::CODE_W-1:0] c;
    ss   = d[3:0];
    ts   = d[6:4];
    cs   = d[8:7];
    ch   = d[103:96];
    slot = ss * NTR + ts;
    n    = 0;
    case (op)
      ccmt_pkg::OP_LOAD_CLASS: class_mem[slot*ccmt_pkg::CHUNKS + cs] = d[72:9];
      ccmt_pkg::OP_LOAD_CODE:  code_mem[slot*NOUT + d[76:73]] = d[85:77];
      ccmt_pkg::OP_LOAD_HDR: begin
        len = d[94:90];
        if (len > NOUT) len = 5'(NOUT);
        hdr_mem[slot] = '{len: len, fallback: d[95], nxt: d[89:86]};
        slot_on[slot] = 1'b1;
      end
      ccmt_pkg::OP_RESTART: cur_st = start_st;
      ccmt_pkg::OP_PROCESS: begin
        if (cur_st != 0) begin
          base   = cur_st * NTR;
          chosen = -1;
          fb     = -1;
          for (int t = 0; t < NTR; t++) begin
            s = base + t;
            if (slot_on[s]) begin
              if (class_mem[s*ccmt_pkg::CHUNKS + ch[7:6]][ch[5:0]]) begin
                chosen = t;
                break;
              end
              if (hdr_mem[s].fallback) fb = t;
            end
          end
          if (chosen < 0) chosen = fb;
          if (chosen >= 0) begin
            s = base + chosen;
            for (int i = 0; i < hdr_mem[s].len; i++) begin
              c = code_mem[s*NOUT + i];
              // codes at or above the echo code repeat the input byte
              run[n] = '{out_char: (c >= ccmt_pkg::CODE_ECHO) ? ch : c[7:0],
                         char_valid: 1'b1, last_run: 1'b0, halted: 1'b0};
              n++;
            end
            cur_st = hdr_mem[s].nxt;
          end
        end
        if (n == 0) begin
          run[0] = '0;
          n = 1;
        end
        run[n-1].last_run = 1'b1;
        for (int k = 0; k < n; k++) begin
          run[k].halted = (cur_st == 0);
          emit_q.push_back(run[k]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    emit_t got;
    emit_t exp;
    if (rst) begin
      foreach (slot_on[i]) slot_on[i] = 1'b0;
      cur_st   = 1;
      start_st = 1;
      emit_q.delete();
      errors   = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ccmt_pkg::REG_START)
        start_st = pwdata[ccmt_pkg::ST_W-1:0];
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got = '{out_char: m_tdata, char_valid: m_tuser[0], last_run: m_tlast,
                halted: m_tuser[1]};
        if (emit_q.size() == 0) begin
          $display("%0t unexpected result transfer: actual %h", $realtime, got);
          errors++;
        end else begin
          exp = emit_q.pop_front();
          if (got.out_char !== exp.out_char) begin
            $display("%0t out_char: expected %h actual %h", $realtime,
                     exp.out_char, got.out_char);
            errors++;
          end
          if (got.char_valid !== exp.char_valid) begin
            $display("%0t char_valid: expected %b actual %b", $realtime,
                     exp.char_valid, got.char_valid);
            errors++;
          end
          if (got.last_run !== exp.last_run) begin
            $display("%0t last_of_run: expected %b actual %b", $realtime,
                     exp.last_run, got.last_run);
            errors++;
          end
          if (got.halted !== exp.halted) begin
            $display("%0t machine_halted: expected %b actual %b", $realtime,
                     exp.halted, got.halted);
            errors++;
          end
        end
      end
    end
    pending = emit_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the character class transducer: programs slot tables, feeds
// bytes and restarts under random stalls on both streams, changes the start
// register between phases; the checker beside the block judges the results
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT = 600000;   // cycle budget, several times the slow run

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         m_tlast;
  logic [1:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic         paddr = 1'b0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int  errors;
  int  pending;
  int  cyc = 0;
  bit  no_idle = 1'b0;     // both sides stream without gaps
  bit  hold_req = 1'b0;    // asks the receiver for one long hold-off
  bit  hold_done = 1'b0;

  // which table entries were written, so no unwritten entry is ever read
  bit [3:0]  chunk_done [128];
  bit [15:0] code_done  [128];

  always #2 clk = ~clk;

  char_class_mealy_transducer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ccmt_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (399) @(negedge clk);
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  function automatic logic [103:0] rand_bits();
    return 104'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // dense, sparse or empty class chunks so fallback slots get exercised
  function automatic logic [63:0] rand_chunk();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return '0;
    if (pick < 7) return ({$urandom, $urandom} & {$urandom, $urandom} &
                          {$urandom, $urandom});
    return {$urandom, $urandom};
  endfunction

  function automatic logic [8:0] rand_code();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return 9'($urandom_range(255));
    if (pick < 9) return ccmt_pkg::CODE_ECHO;
    return 9'($urandom_range(511, 257));
  endfunction

  // every code that a header of this length reads is written
  function automatic bit codes_ready(input int idx, input int len);
    int cnt;
    cnt = (len > 16) ? 16 : len;
    for (int i = 0; i < cnt; i++) begin
      if (!code_done[idx][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // one item transfer, entered and left at a falling edge
  task automatic send(input logic [2:0] op, input logic [103:0] d);
    int gap;
    gap = 0;
    if (!no_idle) while ($urandom_range(99) < 38) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    #1;
    while (!s_tready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic load_chunk(input int st, input int tr, input int cs,
                            input logic [63:0] bits);
    logic [103:0] d;
    d = rand_bits();
    d[3:0] = 4'(st); d[6:4] = 3'(tr); d[8:7] = 2'(cs); d[72:9] = bits;
    chunk_done[st*8+tr][cs] = 1'b1;
    send(ccmt_pkg::OP_LOAD_CLASS, d);
  endtask

  task automatic load_code(input int st, input int tr, input int pos,
                           input logic [8:0] code);
    logic [103:0] d;
    d = rand_bits();
    d[3:0] = 4'(st); d[6:4] = 3'(tr); d[76:73] = 4'(pos); d[85:77] = code;
    code_done[st*8+tr][pos] = 1'b1;
    send(ccmt_pkg::OP_LOAD_CODE, d);
  endtask

  task automatic load_hdr(input int st, input int tr, input int nx, input int len,
                          input bit ca);
    logic [103:0] d;
    d = rand_bits();
    d[3:0] = 4'(st); d[6:4] = 3'(tr); d[89:86] = 4'(nx); d[94:90] = 5'(len);
    d[95] = ca;
    send(ccmt_pkg::OP_LOAD_HDR, d);
  endtask

  task automatic process(input logic [7:0] ch);
    logic [103:0] d;
    d = rand_bits();
    d[103:96] = ch;
    send(ccmt_pkg::OP_PROCESS, d);
  endtask

  // full slot: all four chunks, the codes its length reads, then the header
  task automatic prog_slot(input int st, input int tr, input int nx, input int len,
                           input bit ca, input logic [255:0] cls,
                           input logic [143:0] codes);
    int cnt;
    cnt = (len > 16) ? 16 : len;
    for (int c = 0; c < 4; c++) load_chunk(st, tr, c, cls[64*c +: 64]);
    for (int i = 0; i < cnt; i++) load_code(st, tr, i, codes[9*i +: 9]);
    load_hdr(st, tr, nx, len, ca);
  endtask

  // register write in setup and access cycles, only with the block idle
  task automatic write_start(input logic [3:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= ccmt_pkg::REG_START;
    pwdata <= {$urandom} & 32'hFFFF_FFF0 | 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every expected result, then the worst-case tail of the block
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    logic [255:0] cls;
    logic [143:0] codes;
    int  pick;
    int  st;
    int  tr;
    int  len;
    logic [103:0] d;
    foreach (chunk_done[i]) begin
      chunk_done[i] = '0;
      code_done[i]  = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_start(4'd1);

    // directed: empty state, ignored opcodes, first match, fallback, end
    process(8'h00);
    d = rand_bits();
    send(3'd5, d);
    d = ~d;
    send(3'd7, d);
    cls = '0; cls[8'h41] = 1'b1;
    codes = '0; codes[8:0] = ccmt_pkg::CODE_ECHO; codes[17:9] = 9'h0FF;
    prog_slot(1, 0, 2, 2, 1'b0, cls, codes);
    cls = '0;
    for (int i = 0; i < 16; i++) codes[9*i +: 9] = (i == 3) ? 9'h1FF : rand_code();
    prog_slot(1, 7, 1, 31, 1'b1, cls, codes);   // length beyond max saturates
    process(8'h41);                              // match, echo, to state 2
    process(8'hFF);                              // state 2 empty, holds
    cls = '0; cls[255:192] = '1;
    codes = '0;
    prog_slot(2, 0, 0, 1, 1'b0, cls, codes);
    process(8'hFF);                              // emits zero byte, halts
    process(8'h80);                              // halted, empty result
    send(ccmt_pkg::OP_RESTART, rand_bits());
    process(8'h42);                              // fallback, sixteen bytes

    drain();
    write_start(4'd15);
    send(ccmt_pkg::OP_RESTART, rand_bits());
    process(8'h00);                              // unprogrammed state 15
    drain();
    write_start(4'd1);
    send(ccmt_pkg::OP_RESTART, rand_bits());

    // random phase
    for (int it = 0; it < 105; it++) begin
      if (it == 15) hold_req = 1'b1;
      if (it == 45) begin
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (it == 70) no_idle = 1'b1;
      if (it == 90) no_idle = 1'b0;
      if (it == 35 || it == 60 || it == 95) begin
        drain();
        write_start((it == 60) ? 4'd15 : 4'($urandom_range(15, 1)));
      end
      pick = $urandom_range(99);
      st = ($urandom_range(9) < 8) ? $urandom_range(4, 1) : $urandom_range(15);
      tr = $urandom_range(7);
      if (pick < 12) begin
        for (int c = 0; c < 4; c++) cls[64*c +: 64] = rand_chunk();
        for (int i = 0; i < 16; i++) codes[9*i +: 9] = rand_code();
        len = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(31, 15);
        prog_slot(st, tr,
                  ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(15),
                  len, 1'($urandom_range(1)), cls, codes);
      end else if (pick < 82) begin
        process(8'($urandom));
      end else if (pick < 90) begin
        send(ccmt_pkg::OP_RESTART, rand_bits());
      end else if (pick < 94) begin
        d = rand_bits();
        send(3'($urandom_range(7, 5)), d);
      end else if (pick < 97) begin
        if ($urandom_range(1)) load_chunk(st, tr, $urandom_range(3), rand_chunk());
        else load_code(st, tr, $urandom_range(15), rand_code());
      end else begin
        // header rewrite only where everything it reads is already written
        len = $urandom_range(31);
        if (chunk_done[st*8+tr] == 4'hF && codes_ready(st*8+tr, len))
          load_hdr(st, tr, $urandom_range(15), len, 1'($urandom_range(1)));
        else
          process(8'($urandom));
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- char_class_mealy_transducer_unit.f -----
rtl/ccmt_pkg.sv
rtl/ccmt_ram.sv
rtl/ccmt_slot_eval.sv
rtl/char_class_mealy_transducer_unit.sv
tb/ccmt_checker.sv
tb/tb.sv
